// ----- src/double_click_detector_defines.svh -----
// ----------------------------------------------------------------------------
// Double click detector assertion macros
// Shared macros for the concurrent checks of the double click detector.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_CLICK_DETECTOR_DEFINES_SVH
`define DOUBLE_CLICK_DETECTOR_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define DCD_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define DCD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ----- src/dcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Double click detector package
// Payload types, register indexes, event codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int TIME_W     = 24;
    localparam int DIST_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLICK_DIST    = 2'd1;

    localparam logic [TIME_W-1:0] DOUBLE_CLICK_TIME_RESET = 24'd300000;
    localparam logic [DIST_W-1:0] MAX_CLICK_DIST_RESET    = 10'd6;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         button;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        stamp_us;
        logic [3:0]         modifier_keys;
        logic               from_mouse;
    } dcd_in_t;

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic [2:0]         click_button;
        logic [31:0]        click_time_us;
        logic [3:0]         click_modifiers;
    } dcd_out_t;

    typedef struct packed {
        logic awaiting;
        logic phase;
    } dcd_status_t;

endpackage

`default_nettype wire

// ----- src/dcd_in_stage.sv -----
// ----------------------------------------------------------------------------
// Double click detector input stage
// Holds one accepted event until the click engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dcd_pkg::dcd_in_t in_data,
    input  wire logic           take,
    output logic                stage_valid,
    output dcd_pkg::dcd_in_t    stage_data
);
    import dcd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    dcd_in_t data_reg;
    logic    accept;

    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_data;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/dcd_engine.sv -----
// ----------------------------------------------------------------------------
// Double click detector click engine
// Keeps the click state and press history and checks time and distance.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    input  wire dcd_pkg::dcd_in_t             item,
    input  wire logic                         slot_free,
    input  wire logic [dcd_pkg::TIME_W-1:0]   click_time,
    input  wire logic [dcd_pkg::DIST_W-1:0]   click_dist,
    output logic                              take,
    output logic                              emit,
    output dcd_pkg::dcd_out_t                 result,
    output dcd_pkg::dcd_status_t              status
);
    import dcd_pkg::*;

    logic               awaiting_reg;
    logic               awaiting_next;
    logic               phase_reg;
    logic               phase_next;
    logic               last_valid_reg;
    logic               last_valid_next;
    logic [2:0]         last_id_reg;
    logic [2:0]         last_id_next;
    logic signed [15:0] px_reg [2];
    logic signed [15:0] py_reg [2];
    logic [31:0]        stamp_reg [2];

    logic               is_press;
    logic               is_release;
    logic               sel;
    logic               wr_en;
    logic [31:0]        gap;
    logic               time_ok;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] sqx;
    logic signed [33:0] sqy;
    logic [32:0]        d2;
    logic [19:0]        lim;
    logic               dist_ok;
    logic               in_limits;

    assign take = item_valid && slot_free;

    assign is_press   = item.from_mouse && (item.kind == KIND_PRESS) && !awaiting_reg;
    assign is_release = item.from_mouse && (item.kind == KIND_RELEASE) && awaiting_reg
                        && (item.button == last_id_reg);

    assign sel = is_release ? phase_reg : 1'b0;

    assign gap     = item.stamp_us - stamp_reg[sel];
    assign time_ok = gap <= {8'd0, click_time};

    assign dx  = {item.pos_x[15], item.pos_x} - {px_reg[sel][15], px_reg[sel]};
    assign dy  = {item.pos_y[15], item.pos_y} - {py_reg[sel][15], py_reg[sel]};
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign d2  = {1'b0, sqx[31:0]} + {1'b0, sqy[31:0]};
    assign lim = click_dist * click_dist;
    assign dist_ok   = d2 <= {13'd0, lim};
    assign in_limits = time_ok && dist_ok;

    always_comb
    begin
        awaiting_next   = awaiting_reg;
        phase_next      = phase_reg;
        last_valid_next = last_valid_reg;
        last_id_next    = last_id_reg;
        wr_en           = 1'b0;
        emit            = 1'b0;
        if (take && is_press)
        begin
            if (last_valid_reg && (item.button != last_id_reg))
            begin
                phase_next = 1'b0;
            end
            else if (phase_reg && !in_limits)
            begin
                phase_next = 1'b0;
            end
            last_id_next    = item.button;
            last_valid_next = 1'b1;
            awaiting_next   = 1'b1;
            wr_en           = 1'b1;
        end
        else if (take && is_release)
        begin
            awaiting_next = 1'b0;
            if (!in_limits)
            begin
                phase_next = 1'b0;
            end
            else if (!phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                emit       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            last_valid_reg <= 1'b0;
            last_id_reg    <= 3'd0;
        end
        else
        begin
            awaiting_reg   <= awaiting_next;
            phase_reg      <= phase_next;
            last_valid_reg <= last_valid_next;
            last_id_reg    <= last_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            px_reg[phase_next]    <= item.pos_x;
            py_reg[phase_next]    <= item.pos_y;
            stamp_reg[phase_next] <= item.stamp_us;
        end
    end

    always_comb
    begin
        result.first_x         = px_reg[0];
        result.first_y         = py_reg[0];
        result.click_button    = item.button;
        result.click_time_us   = item.stamp_us;
        result.click_modifiers = item.modifier_keys;
    end

    assign status.awaiting = awaiting_reg;
    assign status.phase    = phase_reg;

endmodule

`default_nettype wire

// ----- src/dcd_out_stage.sv -----
// ----------------------------------------------------------------------------
// Double click detector output stage
// Holds one double click result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire dcd_pkg::dcd_out_t result,
    output logic                   slot_free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dcd_pkg::dcd_out_t      out_data
);
    import dcd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dcd_out_t data_reg;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/double_click_detector.sv -----
// The double click detector takes one mouse event per cycle while the result register
// can take a result, and returns one result for each completed double click, which moves
// from the completing release through the input register and click engine into the
// result register. An event waits in the input register until the engine takes it, then
// the engine checks it against the stored press in a single pass of one subtract and
// compare for the time gap and two 17-bit squarings with an add and compare for the
// distance, and the result register holds the double click until it is taken. Configuration
// writes are taken in any cycle and should only be made while no event is in flight.
// ----------------------------------------------------------------------------
// Double click detector top level
// Input register, click engine, result register and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_click_detector_defines.svh"

module double_click_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire dcd_pkg::dcd_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output dcd_pkg::dcd_out_t                     out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dcd_pkg::*;

    logic [TIME_W-1:0] click_time_reg;
    logic [DIST_W-1:0] click_dist_reg;
    logic              stage_valid;
    dcd_in_t           stage_data;
    logic              take;
    logic              emit;
    logic              slot_free;
    dcd_out_t          result;
    dcd_status_t       status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_time_reg <= DOUBLE_CLICK_TIME_RESET;
            click_dist_reg <= MAX_CLICK_DIST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DOUBLE_CLICK_TIME: click_time_reg <= cfg_data[TIME_W-1:0];
                CFG_MAX_CLICK_DIST:    click_dist_reg <= cfg_data[DIST_W-1:0];
                default:               ;
            endcase
        end
    end

    dcd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    dcd_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stage_valid),
        .item       (stage_data),
        .slot_free  (slot_free),
        .click_time (click_time_reg),
        .click_dist (click_dist_reg),
        .take       (take),
        .emit       (emit),
        .result     (result),
        .status     (status)
    );

    dcd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .result    (result),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `DCD_ASSERT_SAME(a_emit_in_second_click, emit, status.awaiting && status.phase,
        "Result emitted outside the second click.")
    `DCD_ASSERT_NEXT(a_emit_clears_state, emit, !status.awaiting && !status.phase,
        "Click state not cleared after a double click.")
    `DCD_ASSERT_SAME(a_stall_only_when_full, !in_ready, stage_valid && !take,
        "Input stalled while the input register could move.")
    `DCD_ASSERT_SAME(a_out_rise_from_emit, $rose(out_valid), $past(emit),
        "Result appeared without a completed double click.")

endmodule

`default_nettype wire
